// File: rtl/cfo_crystal_cap_tracker_unit_defines.svh
// Assertion macros for the crystal cap tracker checker.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef CFO_CRYSTAL_CAP_TRACKER_UNIT_DEFINES_SVH
`define CFO_CRYSTAL_CAP_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is active
`define CFOCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cfoct assertion failed");

// Next-cycle implication, disabled while reset is active
`define CFOCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cfoct assertion failed");

`endif

// File: rtl/cfoct_pkg.sv
// Shared types, widths and constants of the crystal cap tracker.
// No dependencies; every other source file but the macros header imports this package.
`default_nettype none

package cfoct_pkg;

    // Core widths
    localparam int COUNT_BITS = 16;
    localparam int SUM_BITS   = 24;
    localparam int CFO_BITS   = 8;

    // Scaled magnitude 2.5*|sum| needs one bit more than the sum
    localparam int MAG_W      = SUM_BITS + 1;
    localparam int STEP_W     = $clog2(MAG_W + 1);
    localparam int KSUM_W     = MAG_W + 2;

    // Result and threshold widths
    localparam int AVG_W      = 10;
    localparam int AVG_EXT_W  = AVG_W + 1;
    localparam int CAP_W      = 6;
    localparam int CAP_EXT_W  = CAP_W + 2;
    localparam int TH_W       = 9;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRACK_ENABLE = 8'd0,
        REG_INITIAL_CAP  = 8'd1,
        REG_ENABLE_TH    = 8'd2,
        REG_STOP_TH      = 8'd3
    } t_reg_idx;

    // Reset values of the registers
    localparam logic [CAP_W-1:0] CAP_RESET   = 6'd32;
    localparam logic [TH_W-1:0]  EN_TH_RESET = 9'd20;
    localparam logic [TH_W-1:0]  ST_TH_RESET = 9'd10;

    // Average clamp bounds
    localparam logic signed [KSUM_W-1:0] AVG_HI = KSUM_W'(511);
    localparam logic signed [KSUM_W-1:0] AVG_LO = -KSUM_W'(512);

    // Step thresholds and cap limit
    localparam logic signed [AVG_EXT_W-1:0] STEP_TH8 = AVG_EXT_W'(60);
    localparam logic signed [AVG_EXT_W-1:0] STEP_TH4 = AVG_EXT_W'(30);
    localparam logic signed [AVG_EXT_W-1:0] STEP_TH2 = AVG_EXT_W'(15);
    localparam logic signed [CAP_EXT_W-1:0] CAP_MAX  = CAP_EXT_W'(8'h3f);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_A,
        ST_DIV_B,
        ST_AVG,
        ST_ADJ
    } t_state;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // 2.5 * |s| with integer parts: 2*m + m/2
    function automatic logic [MAG_W-1:0] f_scale_mag(input logic signed [SUM_BITS-1:0] s);
        logic [SUM_BITS-1:0] m;
        m = s[SUM_BITS-1] ? SUM_BITS'(-s) : SUM_BITS'(s);
        return {m, 1'b0} + {2'b00, m[SUM_BITS-1:1]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/cfoct_if.sv
// Channel interfaces of the crystal cap tracker: input, result and register write.
// Depends on cfoct_pkg.
`default_nettype none

interface cfoct_in_if;
    import cfoct_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic signed [CFO_BITS-1:0] cfo_path_a;
    logic signed [CFO_BITS-1:0] cfo_path_b;
    logic                       linked;

    modport source (output valid, action, cfo_path_a, cfo_path_b, linked, input ready);
    modport sink   (input valid, action, cfo_path_a, cfo_path_b, linked, output ready);
endinterface

interface cfoct_out_if;
    import cfoct_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    evaluated;
    logic signed [AVG_W-1:0] cfo_avg_khz;
    logic                    adjusting;
    logic [CAP_W-1:0]        xtal_cap;
    logic                    cap_written;

    modport source (output valid, evaluated, cfo_avg_khz, adjusting, xtal_cap, cap_written,
                    input ready);
    modport sink   (input valid, evaluated, cfo_avg_khz, adjusting, xtal_cap, cap_written,
                    output ready);
endinterface

interface cfoct_cfg_if;
    import cfoct_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/cfoct_accum.sv
// Per-path saturating CFO sums and the shared saturating packet count.
// Depends on cfoct_pkg.
`default_nettype none

module cfoct_accum (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_add,
    input  logic                                 i_clear,
    input  logic signed [cfoct_pkg::CFO_BITS-1:0] i_cfo_a,
    input  logic signed [cfoct_pkg::CFO_BITS-1:0] i_cfo_b,
    output logic signed [cfoct_pkg::SUM_BITS-1:0] o_sum_a,
    output logic signed [cfoct_pkg::SUM_BITS-1:0] o_sum_b,
    output logic [cfoct_pkg::COUNT_BITS-1:0]      o_count
);
    import cfoct_pkg::*;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    logic signed [SUM_BITS-1:0] r_sum_a, r_sum_b, n_sum_a, n_sum_b;
    logic [COUNT_BITS-1:0]      r_count;

    // Add one report and clamp at the signed limits
    function automatic logic signed [SUM_BITS-1:0] f_sat_add(
        input logic signed [SUM_BITS-1:0] s,
        input logic signed [CFO_BITS-1:0] c
    );
        logic signed [SUM_BITS:0] t;
        t = $signed({s[SUM_BITS-1], s}) +
            $signed({{(SUM_BITS+1-CFO_BITS){c[CFO_BITS-1]}}, c});
        if (t[SUM_BITS] != t[SUM_BITS-1]) begin
            return t[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end
        return t[SUM_BITS-1:0];
    endfunction

    assign n_sum_a = f_sat_add(r_sum_a, i_cfo_a);
    assign n_sum_b = f_sat_add(r_sum_b, i_cfo_b);

    // Accumulate on a sample word, drop everything after an evaluation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_count <= '0;
        end else if (i_clear) begin
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_count <= '0;
        end else if (i_add) begin
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            if (r_count != '1) begin
                r_count <= r_count + COUNT_BITS'(1);
            end
        end
    end

    assign o_sum_a = r_sum_a;
    assign o_sum_b = r_sum_b;
    assign o_count = r_count;

endmodule

`default_nettype wire

// File: rtl/cfoct_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on cfoct_pkg; used for both path averages in turn.
`default_nettype none

module cfoct_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [cfoct_pkg::MAG_W-1:0]       i_dividend,
    input  logic [cfoct_pkg::COUNT_BITS-1:0]  i_divisor,
    output cfoct_pkg::t_div_stat              o_stat,
    output logic [cfoct_pkg::MAG_W-1:0]       o_quotient
);
    import cfoct_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_cnt;
    logic [COUNT_BITS-1:0] r_rem;
    logic [MAG_W-1:0]      r_quo;
    logic [COUNT_BITS-1:0] r_div;
    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  fits;

    // Shift the next dividend bit into the remainder and try to subtract
    assign trial = {r_rem, r_quo[MAG_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = trial >= {1'b0, r_div};

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == STEP_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            r_quo <= {r_quo[MAG_W-2:0], fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

`default_nettype wire

// File: rtl/cfo_crystal_cap_tracker_unit.sv
// Top level of the crystal cap tracker: sequencer, averaging and cap stepping.
// Depends on cfoct_pkg, cfoct_if, cfoct_accum and cfoct_div.
//
// Usage:
//   i_in carries words: action 0 is a packet sample (two per-path CFO reports),
//   action 1 is a tracking tick (with the linked flag). o_res carries one result
//   word per tick and none per sample. i_cfg writes the four registers; it is
//   always ready, but it is to be written only while the block is idle; the
//   block itself does not enforce this. A sample is added to the sums when
//   accepted and i_in stays ready for the next cycle. A tick that does not
//   evaluate (disabled, unlinked or no samples) goes to the adjust state, and
//   its result becomes valid when i_in is ready again. An evaluating tick runs
//   both path averages, path A and then path B, through one shared bit-serial
//   divider, MAG_W = SUM_BITS + 1 steps each, then passes the averaging state
//   and the adjust state; i_in is not ready until the tick is back in idle.
//   The result sits in an output register; a stalled receiver holds it, and a
//   tick waits in its adjust cycle until that register is free.
//   Reset clears the sums, count and adjust flag, loads the cap with 32 and
//   restores the register defaults (tracking off, thresholds 20 and 10 kHz).
`default_nettype none

module cfo_crystal_cap_tracker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfoct_in_if.sink    i_in,
    cfoct_out_if.source o_res,
    cfoct_cfg_if.sink   i_cfg
);
    import cfoct_pkg::*;

    t_state r_state, n_state;

    // Registers
    logic             r_track_en;
    logic [TH_W-1:0]  r_en_th;
    logic [TH_W-1:0]  r_st_th;
    logic [CAP_W-1:0] r_cap;
    logic             r_adjust;

    // Work values of one tick
    logic                    r_eval;
    logic                    r_neg_a, r_neg_b;
    logic [MAG_W-1:0]        r_q_a;
    logic signed [AVG_W-1:0] r_avg;

    // Output register
    logic                    r_out_valid;
    logic                    r_out_eval;
    logic signed [AVG_W-1:0] r_out_avg;
    logic                    r_out_adj;
    logic [CAP_W-1:0]        r_out_cap;
    logic                    r_out_wr;

    logic                          in_acc, tick, sample, cond, out_free;
    logic                          div_start, acc_clear;
    logic [MAG_W-1:0]              div_dividend, quotient;
    t_div_stat                     div_stat;
    logic signed [SUM_BITS-1:0]    sum_a, sum_b;
    logic [COUNT_BITS-1:0]         count;

    logic signed [MAG_W:0]         k_a, k_b;
    logic signed [KSUM_W-1:0]      k_sum, k_rnd, k_half;
    logic signed [AVG_W-1:0]       avg_clamped;

    logic signed [AVG_EXT_W-1:0]   avg_x, en_x, st_x, mag;
    logic                          flag_n;
    logic [3:0]                    step;
    logic signed [CAP_EXT_W-1:0]   cap_t;
    logic [CAP_W-1:0]              cap_new;
    logic                          wr_new;

    // Handshake decode
    assign i_in.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc   = i_in.valid && i_in.ready;
    assign tick     = in_acc && i_in.action;
    assign sample   = in_acc && !i_in.action;
    assign cond     = r_track_en && i_in.linked && (count != '0);
    assign out_free = !r_out_valid || o_res.ready;

    cfoct_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_add   (sample),
        .i_clear (acc_clear),
        .i_cfo_a (i_in.cfo_path_a),
        .i_cfo_b (i_in.cfo_path_b),
        .o_sum_a (sum_a),
        .o_sum_b (sum_b),
        .o_count (count)
    );

    // Path A goes in from idle, path B when A finishes
    assign div_dividend = (r_state == ST_IDLE) ? f_scale_mag(sum_a) : f_scale_mag(sum_b);

    cfoct_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (count),
        .o_stat     (div_stat),
        .o_quotient (quotient)
    );

    // Sequencer
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        acc_clear = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (tick) begin
                    if (cond) begin
                        div_start = 1'b1;
                        n_state   = ST_DIV_A;
                    end else begin
                        n_state = ST_ADJ;
                    end
                end
            end
            ST_DIV_A: begin
                if (div_stat.done) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV_B;
                end
            end
            ST_DIV_B: begin
                if (div_stat.done) begin
                    n_state = ST_AVG;
                end
            end
            ST_AVG: begin
                acc_clear = 1'b1;
                n_state   = ST_ADJ;
            end
            ST_ADJ: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Signed path averages, their mean truncated toward zero, then clamp
    always_comb begin
        k_a    = r_neg_a ? -$signed({1'b0, r_q_a}) : $signed({1'b0, r_q_a});
        k_b    = r_neg_b ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
        k_sum  = KSUM_W'(k_a) + KSUM_W'(k_b);
        k_rnd  = k_sum + $signed({{(KSUM_W-1){1'b0}}, k_sum[KSUM_W-1]});
        k_half = k_rnd >>> 1;
        if (k_half > AVG_HI) begin
            avg_clamped = AVG_HI[AVG_W-1:0];
        end else if (k_half < AVG_LO) begin
            avg_clamped = AVG_LO[AVG_W-1:0];
        end else begin
            avg_clamped = k_half[AVG_W-1:0];
        end
    end

    // Hysteresis and cap step
    always_comb begin
        avg_x = AVG_EXT_W'(r_avg);
        en_x  = $signed({2'b00, r_en_th});
        st_x  = $signed({2'b00, r_st_th});
        mag   = avg_x[AVG_EXT_W-1] ? -avg_x : avg_x;
        if (r_adjust) begin
            flag_n = !((avg_x < st_x) && (avg_x > -st_x));
        end else begin
            flag_n = (avg_x > en_x) || (avg_x < -en_x);
        end
        priority if (mag > STEP_TH8) begin
            step = 4'd8;
        end else if (mag > STEP_TH4) begin
            step = 4'd4;
        end else if (mag > STEP_TH2) begin
            step = 4'd2;
        end else begin
            step = 4'd1;
        end
        cap_t = $signed({2'b00, r_cap});
        if (avg_x > st_x) begin
            cap_t = cap_t + $signed({4'b0000, step});
        end else if (avg_x < -st_x) begin
            cap_t = cap_t - $signed({4'b0000, step});
        end
        if (cap_t > CAP_MAX) begin
            cap_new = CAP_MAX[CAP_W-1:0];
        end else if (cap_t < 0) begin
            cap_new = '0;
        end else begin
            cap_new = cap_t[CAP_W-1:0];
        end
        wr_new = r_eval && flag_n && (cap_new != r_cap);
    end

    // Control state, tracking state and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_track_en  <= 1'b0;
            r_en_th     <= EN_TH_RESET;
            r_st_th     <= ST_TH_RESET;
            r_cap       <= CAP_RESET;
            r_adjust    <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_ADJ) && out_free) begin
                r_out_valid <= 1'b1;
                if (r_eval) begin
                    r_adjust <= flag_n;
                    if (flag_n) begin
                        r_cap <= cap_new;
                    end
                end
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_TRACK_ENABLE: r_track_en <= i_cfg.data[0];
                    REG_INITIAL_CAP:  r_cap      <= i_cfg.data[CAP_W-1:0];
                    REG_ENABLE_TH:    r_en_th    <= i_cfg.data[TH_W-1:0];
                    REG_STOP_TH:      r_st_th    <= i_cfg.data[TH_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // Tick work values and result payload
    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_eval  <= cond;
            r_neg_a <= sum_a[SUM_BITS-1];
            r_neg_b <= sum_b[SUM_BITS-1];
            if (!cond) begin
                r_avg <= '0;
            end
        end
        if ((r_state == ST_DIV_A) && div_stat.done) begin
            r_q_a <= quotient;
        end
        if (r_state == ST_AVG) begin
            r_avg <= avg_clamped;
        end
        if ((r_state == ST_ADJ) && out_free) begin
            r_out_eval <= r_eval;
            r_out_avg  <= r_avg;
            r_out_adj  <= r_eval ? flag_n : r_adjust;
            r_out_cap  <= (r_eval && flag_n) ? cap_new : r_cap;
            r_out_wr   <= wr_new;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.evaluated   = r_out_eval;
    assign o_res.cfo_avg_khz = r_out_avg;
    assign o_res.adjusting   = r_out_adj;
    assign o_res.xtal_cap    = r_out_cap;
    assign o_res.cap_written = r_out_wr;

endmodule

`default_nettype wire

// File: rtl/cfoct_checker.sv
// Port-level checks of the crystal cap tracker, bound to the top level.
// Depends on cfoct_pkg and the assertion macros header.
`default_nettype none

`include "cfo_crystal_cap_tracker_unit_defines.svh"

module cfoct_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               i_in_ready,
    input wire logic                               i_in_action,
    input wire logic                               i_out_valid,
    input wire logic                               i_out_ready,
    input wire logic                               i_out_evaluated,
    input wire logic signed [cfoct_pkg::AVG_W-1:0] i_out_avg,
    input wire logic                               i_out_cap_written
);
    import cfoct_pkg::*;

    // A result word holds until taken
    `CFOCT_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)

    // After a sample word the input stays open
    `CFOCT_ASSERT_NEXT(a_sample_one_cycle, i_in_valid && i_in_ready && !i_in_action, i_in_ready)

    // A tick closes the input while it is worked on
    `CFOCT_ASSERT_NEXT(a_tick_busy, i_in_valid && i_in_ready && i_in_action, !i_in_ready)

    // A tick without evaluation reports a zero average and no cap write
    `CFOCT_ASSERT_NOW(a_idle_tick, i_out_valid && i_out_ready && !i_out_evaluated,
        !i_out_cap_written && (i_out_avg == '0))

endmodule

bind cfo_crystal_cap_tracker_unit cfoct_checker u_cfoct_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_in_action       (i_in.action),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_out_evaluated   (o_res.evaluated),
    .i_out_avg         (o_res.cfo_avg_khz),
    .i_out_cap_written (o_res.cap_written)
);

`default_nettype wire

// File: tb/cfo_crystal_cap_tracker_unit_tb.sv
`timescale 1ns / 1ps
// Testbench of the crystal cap tracker: directed table, then random packet bursts and ticks.
// Depends on cfoct_pkg, cfoct_if and the cfo_crystal_cap_tracker_unit RTL.

module cfo_crystal_cap_tracker_unit_tb;
    import cfoct_pkg::*;

    // Word codes and run sizing
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hff;
    localparam int DIR_ROWS     = 24;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 250;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam longint SUM_HI   = (longint'(1) <<< (SUM_BITS - 1)) - 1;
    localparam longint SUM_LO   = -SUM_HI - 1;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic                       action;
        logic signed [CFO_BITS-1:0] cfo_a;
        logic signed [CFO_BITS-1:0] cfo_b;
        logic                       linked;
    } t_in_word;

    typedef struct packed {
        logic                    evaluated;
        logic signed [AVG_W-1:0] avg_khz;
        logic                    adjusting;
        logic [CAP_W-1:0]        cap;
        logic                    written;
    } t_tick_res;

    typedef struct packed {
        t_row_kind             kind;
        t_in_word              word;
        logic [31:0]           reps;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  typed;
        t_tick_res             want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cfoct_in_if  in_ch();
    cfoct_out_if res_ch();
    cfoct_cfg_if cfg_ch();

    cfo_crystal_cap_tracker_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Tracker state mirror
    logic signed [SUM_BITS-1:0] path_sum [2];
    logic [COUNT_BITS-1:0]      pkt_count;
    logic [CAP_W-1:0]           cap_now;
    logic                       adj_now;
    logic                       trk_en;
    logic [TH_W-1:0]            en_th;
    logic [TH_W-1:0]            st_th;

    t_tick_res   due_results[$];
    t_dir_row    dir_tab [DIR_ROWS];
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned fail_count = 0;
    int unsigned checked_results = 0;
    int unsigned words_sent = 0;
    int unsigned cycle_count = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit roll(input int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void reset_mirror();
        path_sum[0] = '0;
        path_sum[1] = '0;
        pkt_count   = '0;
        trk_en      = 1'b0;
        en_th       = EN_TH_RESET;
        st_th       = ST_TH_RESET;
        cap_now     = CAP_RESET;
        adj_now     = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_TRACK_ENABLE: trk_en = data[0];
            REG_INITIAL_CAP:  cap_now = data[CAP_W-1:0];
            REG_ENABLE_TH:    en_th = data[TH_W-1:0];
            REG_STOP_TH:      st_th = data[TH_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic signed [SUM_BITS-1:0] sat_sum(input logic signed [SUM_BITS-1:0] s,
                                                          input logic signed [CFO_BITS-1:0] v);
        longint r;
        r = longint'(s) + longint'(v);
        if (r > SUM_HI) r = SUM_HI;
        if (r < SUM_LO) r = SUM_LO;
        return r[SUM_BITS-1:0];
    endfunction

    // Signed 2.5 * |sum| / count, integer parts
    function automatic longint path_khz(input longint s, input longint n);
        longint mag;
        longint k;
        mag = (s < 0) ? -s : s;
        k = (2 * mag + mag / 2) / n;
        return (s < 0) ? -k : k;
    endfunction

    // Advance the mirror by one word; return 1 with the tick result for a tick
    function automatic bit predict_word(input t_in_word w, output t_tick_res r);
        longint avg;
        longint mag;
        longint step;
        longint cap;
        longint en;
        longint st;
        r = '0;
        if (w.action == ACT_SAMPLE) begin
            path_sum[0] = sat_sum(path_sum[0], w.cfo_a);
            path_sum[1] = sat_sum(path_sum[1], w.cfo_b);
            if (pkt_count != '1) pkt_count = pkt_count + 1'b1;
            return 1'b0;
        end
        en = longint'(en_th);
        st = longint'(st_th);
        if (trk_en && w.linked && pkt_count != '0) begin
            avg = (path_khz(longint'(path_sum[0]), longint'(pkt_count)) +
                   path_khz(longint'(path_sum[1]), longint'(pkt_count))) / 2;
            if (avg > AVG_HI) avg = AVG_HI;
            if (avg < AVG_LO) avg = AVG_LO;
            path_sum[0] = '0;
            path_sum[1] = '0;
            pkt_count   = '0;
            r.evaluated = 1'b1;
            r.avg_khz   = avg[AVG_W-1:0];
            // Hysteresis: start above enable, stop inside stop band
            if (!adj_now) begin
                if (avg > en || avg < -en) adj_now = 1'b1;
            end else if (avg < st && avg > -st) begin
                adj_now = 1'b0;
            end
            if (adj_now) begin
                mag  = (avg < 0) ? -avg : avg;
                step = (mag > STEP_TH8) ? 8 : (mag > STEP_TH4) ? 4 : (mag > STEP_TH2) ? 2 : 1;
                cap  = longint'(cap_now);
                if (avg > st) cap = cap + step;
                else if (avg < -st) cap = cap - step;
                if (cap > CAP_MAX) cap = CAP_MAX;
                if (cap < 0) cap = 0;
                if (cap[CAP_W-1:0] != cap_now) begin
                    cap_now   = cap[CAP_W-1:0];
                    r.written = 1'b1;
                end
            end
        end
        r.adjusting = adj_now;
        r.cap       = cap_now;
        return 1'b1;
    endfunction

    function automatic t_tick_res mk_res(input int ev, input int avg, input int adj,
                                        input int cap, input int wr);
        t_tick_res r;
        r.evaluated = 1'(ev);
        r.avg_khz   = AVG_W'(avg);
        r.adjusting = 1'(adj);
        r.cap       = CAP_W'(cap);
        r.written   = 1'(wr);
        return r;
    endfunction

    function automatic t_dir_row row_word(input logic act, input int a, input int b,
                                          input logic lnk, input int reps, input logic typed,
                                          input t_tick_res want);
        t_dir_row r;
        r = '0;
        r.kind        = ROW_WORD;
        r.word.action = act;
        r.word.cfo_a  = CFO_BITS'(a);
        r.word.cfo_b  = CFO_BITS'(b);
        r.word.linked = lnk;
        r.reps        = reps;
        r.typed       = typed;
        r.want        = want;
        return r;
    endfunction

    function automatic t_dir_row row_cfg(input logic [CFG_IDX_W-1:0] idx, input int data);
        t_dir_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = CFG_DATA_W'(data);
        return r;
    endfunction

    // Sample near a burst target, clamped to the report range
    function automatic logic signed [CFO_BITS-1:0] near_target(input int tgt);
        int v;
        v = tgt + $urandom_range(0, 6) - 3;
        if (v > 127) v = 127;
        if (v < -128) v = -128;
        return CFO_BITS'(v);
    endfunction

    function automatic int pick_target();
        if (roll(50)) return $urandom_range(0, 60) - 30;
        return $urandom_range(0, 255) - 128;
    endfunction

    // Offer one word with random leading idle, hold until accepted
    task automatic send_word(input t_in_word w, input bit typed, input t_tick_res want);
        t_tick_res r;
        while (roll(send_idle_pct)) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= w.action;
        in_ch.cfo_path_a <= w.cfo_a;
        in_ch.cfo_path_b <= w.cfo_b;
        in_ch.linked     <= w.linked;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
        if (predict_word(w, r)) due_results.push_back(typed ? want : r);
    endtask

    // Drop valid, wait for every result, then let trailing work settle
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        apply_reg(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receive results, compare against the oldest expectation, randomize ready
    always @(posedge i_clk) begin
        t_tick_res exp_r;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (due_results.size() == 0) begin
                $error("result word with no tick pending");
                fail_count++;
            end else begin
                exp_r = due_results.pop_front();
                checked_results++;
                if (res_ch.evaluated !== exp_r.evaluated) begin
                    $error("evaluated: expected %0d, got %0d", exp_r.evaluated, res_ch.evaluated);
                    fail_count++;
                end
                if (res_ch.cfo_avg_khz !== exp_r.avg_khz) begin
                    $error("cfo_avg_khz: expected %0d, got %0d", exp_r.avg_khz, res_ch.cfo_avg_khz);
                    fail_count++;
                end
                if (res_ch.adjusting !== exp_r.adjusting) begin
                    $error("adjusting: expected %0d, got %0d", exp_r.adjusting, res_ch.adjusting);
                    fail_count++;
                end
                if (res_ch.xtal_cap !== exp_r.cap) begin
                    $error("xtal_cap: expected %0d, got %0d", exp_r.cap, res_ch.xtal_cap);
                    fail_count++;
                end
                if (res_ch.cap_written !== exp_r.written) begin
                    $error("cap_written: expected %0d, got %0d", exp_r.written, res_ch.cap_written);
                    fail_count++;
                end
            end
        end
        res_ch.ready <= !roll(recv_stall_pct);
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, due_results.size());
            $display("[cfo_crystal_cap_tracker_unit] ERROR");
            $finish;
        end
    end

    initial begin
        t_in_word  w;
        t_dir_row  row;
        t_tick_res none;
        int        tgt_a;
        int        tgt_b;
        int        len;
        int        n;
        int        en_v;

        none = '0;
        in_ch.valid      <= 1'b0;
        in_ch.action     <= ACT_SAMPLE;
        in_ch.cfo_path_a <= '0;
        in_ch.cfo_path_b <= '0;
        in_ch.linked     <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;
        i_rst_n          <= 1'b0;
        reset_mirror();

        // Directed table: defaults, enable gate, extremes, saturation, truncation
        dir_tab[0]  = row_word(ACT_TICK, 0, 0, 1'b1, 1, 1'b1, mk_res(0, 0, 0, 32, 0));
        dir_tab[1]  = row_word(ACT_SAMPLE, 127, 127, 1'b0, 1, 1'b0, none);
        dir_tab[2]  = row_word(ACT_TICK, -1, -1, 1'b1, 1, 1'b1, mk_res(0, 0, 0, 32, 0));
        dir_tab[3]  = row_cfg(REG_TRACK_ENABLE, 1);
        dir_tab[4]  = row_word(ACT_TICK, 0, 0, 1'b0, 1, 1'b1, mk_res(0, 0, 0, 32, 0));
        dir_tab[5]  = row_word(ACT_TICK, 0, 0, 1'b1, 1, 1'b1, mk_res(1, 317, 1, 40, 1));
        dir_tab[6]  = row_word(ACT_TICK, 0, 0, 1'b1, 1, 1'b1, mk_res(0, 0, 1, 40, 0));
        dir_tab[7]  = row_word(ACT_SAMPLE, -128, -128, 1'b1, 1, 1'b0, none);
        dir_tab[8]  = row_word(ACT_TICK, 0, 0, 1'b1, 1, 1'b1, mk_res(1, -320, 1, 32, 1));
        dir_tab[9]  = row_word(ACT_SAMPLE, 0, 0, 1'b0, 1, 1'b0, none);
        dir_tab[10] = row_word(ACT_TICK, 0, 0, 1'b1, 1, 1'b1, mk_res(1, 0, 0, 32, 0));
        dir_tab[11] = row_cfg(REG_INITIAL_CAP, 63);
        dir_tab[12] = row_word(ACT_SAMPLE, 127, 127, 1'b0, 1, 1'b0, none);
        dir_tab[13] = row_word(ACT_TICK, 0, 0, 1'b1, 1, 1'b1, mk_res(1, 317, 1, 63, 0));
        dir_tab[14] = row_cfg(REG_INITIAL_CAP, 0);
        dir_tab[15] = row_word(ACT_SAMPLE, -128, -128, 1'b0, 1, 1'b0, none);
        dir_tab[16] = row_word(ACT_TICK, 0, 0, 1'b1, 1, 1'b1, mk_res(1, -320, 1, 0, 0));
        dir_tab[17] = row_cfg(REG_UNMAPPED, 'h1ff);
        dir_tab[18] = row_cfg(REG_INITIAL_CAP, 'h1d4);
        dir_tab[19] = row_word(ACT_SAMPLE, 2, -5, 1'b1, 3, 1'b0, none);
        dir_tab[20] = row_word(ACT_TICK, 85, -86, 1'b1, 1, 1'b0, none);
        dir_tab[21] = row_word(ACT_SAMPLE, 127, -128, 1'b0, 200, 1'b0, none);
        dir_tab[22] = row_word(ACT_TICK, 0, 0, 1'b1, 1, 1'b0, none);
        dir_tab[23] = row_word(ACT_TICK, 0, 0, 1'b1, 1, 1'b0, none);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the table with no idling
        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_tab[i];
            if (row.kind == ROW_CFG) begin
                drain_block();
                write_reg(row.idx, row.data);
            end else begin
                for (int k = 0; k < row.reps; k++) send_word(row.word, row.typed, row.want);
            end
        end

        // Random phases: settings and idling change per phase
        for (int p = 0; p < PHASES; p++) begin
            drain_block();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            case (p)
                0: begin
                    write_reg(REG_TRACK_ENABLE, CFG_DATA_W'(1));
                    write_reg(REG_INITIAL_CAP, CFG_DATA_W'(CAP_RESET));
                    write_reg(REG_ENABLE_TH, CFG_DATA_W'(EN_TH_RESET));
                    write_reg(REG_STOP_TH, CFG_DATA_W'(ST_TH_RESET));
                end
                1: begin
                    write_reg(REG_TRACK_ENABLE, CFG_DATA_W'(1));
                    write_reg(REG_INITIAL_CAP, CFG_DATA_W'(0));
                    write_reg(REG_ENABLE_TH, CFG_DATA_W'(0));
                    write_reg(REG_STOP_TH, CFG_DATA_W'(0));
                end
                2: begin
                    write_reg(REG_TRACK_ENABLE, CFG_DATA_W'(1));
                    write_reg(REG_INITIAL_CAP, CFG_DATA_W'(63));
                    write_reg(REG_ENABLE_TH, CFG_DATA_W'(320));
                    write_reg(REG_STOP_TH, CFG_DATA_W'(320));
                end
                default: begin
                    en_v = $urandom_range(0, 320);
                    write_reg(REG_TRACK_ENABLE, CFG_DATA_W'((p == 3) ? 0 : 1));
                    write_reg(REG_INITIAL_CAP, CFG_DATA_W'($urandom_range(0, 63)));
                    write_reg(REG_ENABLE_TH, CFG_DATA_W'(en_v));
                    write_reg(REG_STOP_TH, CFG_DATA_W'($urandom_range(0, en_v)));
                end
            endcase

            n = 0;
            while (n < PHASE_WORDS) begin
                if (roll(80)) begin
                    // Burst of packets around a steady offset, closed by a tick
                    tgt_a = pick_target();
                    tgt_b = roll(70) ? tgt_a + $urandom_range(0, 10) - 5 : pick_target();
                    len = roll(90) ? $urandom_range(1, 8) : $urandom_range(20, 60);
                    for (int k = 0; k < len; k++) begin
                        w.action = ACT_SAMPLE;
                        w.cfo_a  = near_target(tgt_a);
                        w.cfo_b  = near_target(tgt_b);
                        w.linked = 1'($urandom_range(0, 1));
                        send_word(w, 1'b0, none);
                    end
                    w.action = ACT_TICK;
                    w.cfo_a  = CFO_BITS'($urandom_range(0, 255));
                    w.cfo_b  = CFO_BITS'($urandom_range(0, 255));
                    w.linked = roll(90);
                    send_word(w, 1'b0, none);
                    n += len + 1;
                end else if (roll(50)) begin
                    // Lone tick, often with nothing pending
                    w.action = ACT_TICK;
                    w.cfo_a  = CFO_BITS'($urandom_range(0, 255));
                    w.cfo_b  = CFO_BITS'($urandom_range(0, 255));
                    w.linked = 1'($urandom_range(0, 1));
                    send_word(w, 1'b0, none);
                    n++;
                end else begin
                    // Unshaped packets over the full report range
                    len = $urandom_range(1, 4);
                    for (int k = 0; k < len; k++) begin
                        w.action = ACT_SAMPLE;
                        w.cfo_a  = CFO_BITS'($urandom_range(0, 255));
                        w.cfo_b  = CFO_BITS'($urandom_range(0, 255));
                        w.linked = 1'($urandom_range(0, 1));
                        send_word(w, 1'b0, none);
                    end
                    n += len;
                end
            end
        end

        drain_block();
        if (due_results.size() != 0) begin
            $error("%0d tick results never arrived", due_results.size());
            fail_count++;
        end
        $display("run: %0d words in (directed table plus %0d random phases), %0d tick results",
                 words_sent, PHASES, checked_results);
        $display("run: %0d mismatches after %0d cycles", fail_count, cycle_count);
        if (fail_count == 0) begin
            $display("[cfo_crystal_cap_tracker_unit] OK");
        end else begin
            $display("[cfo_crystal_cap_tracker_unit] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/cfoct_pkg.sv
rtl/cfoct_if.sv
rtl/cfoct_accum.sv
rtl/cfoct_div.sv
rtl/cfo_crystal_cap_tracker_unit.sv
rtl/cfoct_checker.sv
tb/cfo_crystal_cap_tracker_unit_tb.sv
